FILE: rtl/dcs_pkg.sv
// Shared types, widths and codes for the decimating capture block.
`default_nettype none
package dcs_pkg;

  // Storage and field widths
  localparam int DEPTH     = 4096;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COUNT_W   = $clog2(DEPTH) + 1;
  localparam int SAMPLE_W  = 24;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int SUM_W     = 36;
  localparam int SQ_W      = 59;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CAP_W     = 13;
  localparam int OP_W      = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 208;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_PHASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0]      FACTOR_RESET   = 16'd1;
  localparam logic [15:0]      PHASE_RESET    = 16'd0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(DEPTH);

  // Input tdata layout, MSB first
  typedef struct packed {
    logic [2:0]                 pad;
    logic [ADDR_W-1:0]          read_index;
    logic                       sample_enable;
    logic signed [SAMPLE_W-1:0] sample;
  } in_data_t;

  // One input request as seen by the control logic
  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic [ADDR_W-1:0]          read_index;
    logic                       sample_enable;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  // Status after one request, minus the sum of squares
  typedef struct packed {
    logic                       accepted;
    logic                       clear;
    logic                       read_ok;
    logic [COUNT_W-1:0]         stored_count;
    logic                       is_full;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [COUNT_W-1:0]  min_position;
    logic signed [COUNT_W-1:0]  max_position;
    logic signed [SUM_W-1:0]    sum_value;
  } snap_t;

  // Output tdata layout, MSB first
  typedef struct packed {
    logic [SQ_W-1:0]            sum_squares;
    logic signed [SUM_W-1:0]    sum_value;
    logic signed [COUNT_W-1:0]  max_position;
    logic signed [COUNT_W-1:0]  min_position;
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [SAMPLE_W-1:0] min_value;
    logic                       is_full;
    logic [COUNT_W-1:0]         stored_count;
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] read_data;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/decimating_capture_with_stats_unit.sv
// Top level: request intake, store, sum-of-squares stage and result register.
// A request passes the first-stage register, then the result register that
// sets m_tvalid. Throughput: one request per cycle unless the output stalls;
// the store read, the stat update and the squaring multiplier take one stage,
// the 59-bit square accumulate the next.
// Reset clears counters, statistics and handshake state at once; the store
// contents are left as they are and no clearing pass runs.
`default_nettype none
module decimating_capture_with_stats_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // s_tdata: sample[23:0], sample_enable[24], read_index[36:25], zero pad
  input  wire logic [dcs_pkg::IN_DATA_W-1:0]        s_tdata,
  // s_tuser: operation[1:0]
  input  wire logic [dcs_pkg::OP_W-1:0]             s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // m_tdata: read_data[23:0], accepted[24], stored_count[37:25], is_full[38],
  // min_value[62:39], max_value[86:63], min_position[99:87],
  // max_position[112:100], sum_value[148:113], sum_squares[207:149]
  output logic [dcs_pkg::OUT_DATA_W-1:0]            m_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [dcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dcs_pkg::CFG_W-1:0]            cfg_data
);
  import dcs_pkg::*;

  in_data_t in_d;
  item_t    item;
  logic     accept;
  logic     s1_valid, s1_adv;
  snap_t    snap, s1;
  logic signed [PROD_W-1:0]   sq_p;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic [SQ_W-1:0]            run_sum_sq, run_sum_sq_next;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  res_t                       res_q;

  // Request intake
  always_comb begin
    in_d = in_data_t'(s_tdata);
    item.operation     = s_tuser;
    item.read_index    = in_d.read_index;
    item.sample_enable = in_d.sample_enable;
    item.sample        = in_d.sample;
    s1_adv   = s1_valid && (!m_tvalid || m_tready);
    s_tready = !s1_valid || !m_tvalid || m_tready;
    accept   = s_tvalid && s_tready;
  end

  dcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (accept),
    .item      (item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .snap      (snap)
  );

  dcs_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.sample),
    .re    (accept && (item.operation == OP_READ)),
    .raddr (item.read_index),
    .rdata (rd_q)
  );

  // First stage: status snapshot and registered square
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1   <= snap;
      sq_p <= item.sample * item.sample;
    end
  end

  // Sum of squares accumulate
  always_comb begin
    if (s1.clear) begin
      run_sum_sq_next = '0;
    end else if (s1.accepted) begin
      run_sum_sq_next = run_sum_sq + {{(SQ_W-PROD_W){1'b0}}, sq_p};
    end else begin
      run_sum_sq_next = run_sum_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum_sq <= '0;
    end else if (s1_adv) begin
      run_sum_sq <= run_sum_sq_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_q.sum_squares  <= run_sum_sq_next;
      res_q.sum_value    <= s1.sum_value;
      res_q.max_position <= s1.max_position;
      res_q.min_position <= s1.min_position;
      res_q.max_value    <= s1.max_value;
      res_q.min_value    <= s1.min_value;
      res_q.is_full      <= s1.is_full;
      res_q.stored_count <= s1.stored_count;
      res_q.accepted     <= s1.accepted;
      res_q.read_data    <= s1.read_ok ? rd_q : '0;
    end
  end

  assign m_tdata = res_q;

  // A stalled first stage keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("first stage lost a request");

  // A stored sample always shows a nonzero count
  a_acc_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.accepted |-> res_q.stored_count != '0)
    else $error("accepted sample with zero count");

  // A clear reports an empty sum of squares
  a_clear_sq: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.clear |=> res_q.sum_squares == '0)
    else $error("clear left a sum of squares");

endmodule
`default_nettype wire

FILE: rtl/dcs_store.sv
// Sample store: one write port and one registered read port.
`default_nettype none
module dcs_store (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [dcs_pkg::ADDR_W-1:0]            waddr,
  input  wire logic signed [dcs_pkg::SAMPLE_W-1:0]   wdata,
  input  wire logic                                  re,
  input  wire logic [dcs_pkg::ADDR_W-1:0]            raddr,
  output logic signed [dcs_pkg::SAMPLE_W-1:0]        rdata
);
  import dcs_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dcs_ctrl.sv
// Decimation counter, fill count and running min/max/sum update.
`default_nettype none
module dcs_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dcs_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                acc,
  input  wire dcs_pkg::item_t                      item,
  output logic                                     wr_en,
  output logic [dcs_pkg::ADDR_W-1:0]               wr_addr,
  output dcs_pkg::snap_t                           snap
);
  import dcs_pkg::*;

  logic [15:0]      decim_factor;
  logic [15:0]      decim_phase;
  logic [CAP_W-1:0] capacity;

  logic [COUNT_W-1:0]         fill_count, fill_count_next;
  logic [15:0]                phase_count, phase_count_next;
  logic signed [SAMPLE_W-1:0] run_min, run_min_next;
  logic signed [SAMPLE_W-1:0] run_max, run_max_next;
  logic signed [COUNT_W-1:0]  run_min_pos, run_min_pos_next;
  logic signed [COUNT_W-1:0]  run_max_pos, run_max_pos_next;
  logic signed [SUM_W-1:0]    run_sum, run_sum_next;

  logic        is_sample, is_read, is_clear;
  logic        full_now, full_after;
  logic        step, hit;
  logic [15:0] factor_eff;
  logic [16:0] phase_inc;
  logic        first;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decim_factor <= FACTOR_RESET;
      decim_phase  <= PHASE_RESET;
      capacity     <= CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECIM_FACTOR: decim_factor <= cfg_data;
        CFG_DECIM_PHASE:  decim_phase  <= cfg_data;
        CFG_CAPACITY:     capacity     <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode and decimation decision
  always_comb begin
    is_sample  = item.operation == OP_SAMPLE;
    is_read    = item.operation == OP_READ;
    is_clear   = item.operation == OP_CLEAR;
    full_now   = (fill_count >= capacity) || (fill_count >= COUNT_W'(DEPTH));
    step       = acc && is_sample && !full_now && item.sample_enable;
    hit        = step && (phase_count == decim_phase);
    factor_eff = (decim_factor == '0) ? 16'd1 : decim_factor;
    phase_inc  = {1'b0, phase_count} + 17'd1;
    first      = fill_count == '0;
  end

  // Next state of the running statistics
  always_comb begin
    fill_count_next  = fill_count;
    phase_count_next = phase_count;
    run_min_next     = run_min;
    run_max_next     = run_max;
    run_min_pos_next = run_min_pos;
    run_max_pos_next = run_max_pos;
    run_sum_next     = run_sum;
    if (acc && is_clear) begin
      fill_count_next  = '0;
      phase_count_next = '0;
      run_min_next     = '0;
      run_max_next     = '0;
      run_min_pos_next = '1;
      run_max_pos_next = '1;
      run_sum_next     = '0;
    end else begin
      if (step) begin
        phase_count_next = (phase_inc >= {1'b0, factor_eff}) ? 16'd0 : phase_inc[15:0];
      end
      if (hit) begin
        fill_count_next = fill_count + 1'b1;
        if (first || (item.sample < run_min)) begin
          run_min_next     = item.sample;
          run_min_pos_next = $signed(fill_count);
        end
        if (first || (item.sample > run_max)) begin
          run_max_next     = item.sample;
          run_max_pos_next = $signed(fill_count);
        end
        run_sum_next = run_sum + SUM_W'(item.sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      phase_count <= '0;
      run_min     <= '0;
      run_max     <= '0;
      run_min_pos <= '1;
      run_max_pos <= '1;
      run_sum     <= '0;
    end else begin
      fill_count  <= fill_count_next;
      phase_count <= phase_count_next;
      run_min     <= run_min_next;
      run_max     <= run_max_next;
      run_min_pos <= run_min_pos_next;
      run_max_pos <= run_max_pos_next;
      run_sum     <= run_sum_next;
    end
  end

  // Store write and status snapshot
  always_comb begin
    full_after = (fill_count_next >= capacity) || (fill_count_next >= COUNT_W'(DEPTH));
    wr_en   = hit;
    wr_addr = fill_count[ADDR_W-1:0];
    snap.accepted     = hit;
    snap.clear        = is_clear;
    snap.read_ok      = is_read && ({1'b0, item.read_index} < fill_count);
    snap.stored_count = fill_count_next;
    snap.is_full      = full_after;
    snap.min_value    = run_min_next;
    snap.max_value    = run_max_next;
    snap.min_position = run_min_pos_next;
    snap.max_position = run_max_pos_next;
    snap.sum_value    = run_sum_next;
  end

  // Fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= COUNT_W'(DEPTH))
    else $error("fill count beyond store depth");

  // An empty buffer has no extreme positions, a filled one has both
  a_pos_empty: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) == ((run_min_pos == '1) && (run_max_pos == '1)))
    else $error("extreme positions disagree with fill count");

  // Decimation phase moves only on an accepted request
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(phase_count))
    else $error("phase counter moved without a request");

endmodule
`default_nettype wire
